// File: src/hdc_pkg.sv
// shared constants, field widths and types of the huffman bit-serial decoder
// depends on nothing; the other files that use it refer to it by scoped names
`timescale 1ns / 1ps
`default_nettype none

package hdc_pkg;

    // default storage configuration
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_MAX_CODE_LEN  = 16;
    localparam int DEF_SYMBOL_BITS   = 8;

    // fixed widths of the beat fields
    localparam int IDX_FIELD_W  = 6;
    localparam int LEN_FIELD_W  = 5;
    localparam int CODE_FIELD_W = 16;
    localparam int SYM_FIELD_W  = 8;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BIT  = 1'b1;

    // one table entry as seen by the compare unit
    typedef struct packed {
        logic [LEN_FIELD_W-1:0]  len;
        logic [CODE_FIELD_W-1:0] code;
        logic [SYM_FIELD_W-1:0]  sym;
    } entry_t;

endpackage

`default_nettype wire

// File: src/hdc_ram.sv
// generic single write, single read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module hdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/hdc_code_table.sv
// code table: per-entry valid bits plus one ram holding length, code and symbol
// depends on hdc_pkg and hdc_ram
`timescale 1ns / 1ps
`default_nettype none

module hdc_code_table #(
    parameter int TABLE_ENTRIES = hdc_pkg::DEF_TABLE_ENTRIES,
    parameter int SYMBOL_BITS   = hdc_pkg::DEF_SYMBOL_BITS,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [hdc_pkg::IDX_FIELD_W-1:0]  wr_index,
    input  wire logic [hdc_pkg::LEN_FIELD_W-1:0]  wr_len,
    input  wire logic [hdc_pkg::CODE_FIELD_W-1:0] wr_code,
    input  wire logic [hdc_pkg::SYM_FIELD_W-1:0]  wr_sym,
    input  wire logic                             rd_en,
    input  wire logic [IDX_W-1:0]                 rd_addr,
    output hdc_pkg::entry_t                       rd_entry
);

    localparam int RAM_W = hdc_pkg::LEN_FIELD_W + hdc_pkg::CODE_FIELD_W + SYMBOL_BITS;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;
    logic                     wr_ok;
    logic [IDX_W-1:0]         wr_addr;
    logic [RAM_W-1:0]         wr_word;
    logic [RAM_W-1:0]         rd_word;
    logic [SYMBOL_BITS-1:0]   sym_masked;

    // slots beyond the table are dropped
    assign wr_ok      = wr_en && (32'(wr_index) < TABLE_ENTRIES);
    assign wr_addr    = IDX_W'(wr_index);
    assign sym_masked = SYMBOL_BITS'(wr_sym);
    assign wr_word    = {wr_len, wr_code, sym_masked};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    hdc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // never-written slot reads as empty
    always_comb
    begin
        rd_entry.len  = rd_valid_reg
                      ? rd_word[RAM_W-1 -: hdc_pkg::LEN_FIELD_W]
                      : '0;
        rd_entry.code = rd_word[SYMBOL_BITS +: hdc_pkg::CODE_FIELD_W];
        rd_entry.sym  = hdc_pkg::SYM_FIELD_W'(rd_word[SYMBOL_BITS-1:0]);
    end

endmodule

`default_nettype wire

// File: src/hdc_match_unit.sv
// shared compare unit: checks one table entry against the bit accumulator
// depends on hdc_pkg
`timescale 1ns / 1ps
`default_nettype none

module hdc_match_unit #(
    parameter int MAX_CODE_LEN = hdc_pkg::DEF_MAX_CODE_LEN,
    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1)
) (
    input  wire hdc_pkg::entry_t         entry,
    input  wire logic [MAX_CODE_LEN-1:0] acc,
    input  wire logic [CNT_W-1:0]        count,
    output logic                         hit
);

    localparam int LW = (CNT_W > hdc_pkg::LEN_FIELD_W) ? CNT_W : hdc_pkg::LEN_FIELD_W;
    localparam int CW = (MAX_CODE_LEN > hdc_pkg::CODE_FIELD_W)
                      ? MAX_CODE_LEN : hdc_pkg::CODE_FIELD_W;

    logic [CW-1:0] mask;
    logic          len_eq;
    logic          code_eq;

    always_comb
    begin
        mask    = ~({CW{1'b1}} << count);
        len_eq  = (LW'(entry.len) == LW'(count));
        code_eq = ((CW'(entry.code) & mask) == CW'(acc));
        hit     = len_eq && code_eq;
    end

endmodule

`default_nettype wire

// File: src/huffman_bit_serial_decoder_core.sv
// top level of the huffman bit-serial decoder: sequencer, bit accumulator, result register
// depends on hdc_pkg, hdc_code_table and hdc_match_unit
`timescale 1ns / 1ps
`default_nettype none

// A beat is taken at a clock edge where start is high and busy is low. A load beat
// (req_type 0) writes one code table slot at that edge and gives no result;
// busy never rises for it. A bit beat (req_type 1) shifts code_bit into the
// accumulator and then walks the table one slot per cycle through its single read
// port; busy stays high for the whole walk and no beat is taken before it ends.
// A match at a slot ends the walk early. When a beat decodes a symbol, or ends in
// an error (accumulator full, or a final bit left unmatched), result_valid pulses
// for exactly one cycle with symbol, code_length and no_match_error; the receiver
// cannot stall it and must take it in that cycle. Bit beats that leave code bits
// pending give no result. The table is cleared at reset without any sweep, so the
// block takes beats right after reset.

module huffman_bit_serial_decoder_core #(
    parameter int TABLE_ENTRIES = hdc_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_CODE_LEN  = hdc_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_BITS   = hdc_pkg::DEF_SYMBOL_BITS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             req_type,
    input  wire logic [hdc_pkg::IDX_FIELD_W-1:0]  entry_index,
    input  wire logic [hdc_pkg::LEN_FIELD_W-1:0]  entry_length,
    input  wire logic [hdc_pkg::CODE_FIELD_W-1:0] entry_code,
    input  wire logic [hdc_pkg::SYM_FIELD_W-1:0]  entry_symbol,
    input  wire logic                             code_bit,
    input  wire logic                             final_bit,
    output logic                                  result_valid,
    output logic [hdc_pkg::SYM_FIELD_W-1:0]       symbol,
    output logic [hdc_pkg::LEN_FIELD_W-1:0]       code_length,
    output logic                                  no_match_error
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_CODE_LEN);

    // one-hot sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                         state_reg,   state_next;
    logic [MAX_CODE_LEN-1:0]        acc_reg,     acc_next;
    logic [CNT_W-1:0]               count_reg,   count_next;
    logic                           fin_reg,     fin_next;
    logic [IDX_W-1:0]               issue_reg,   issue_next;
    logic                           issued_reg,  issued_next;   // every slot read issued
    logic                           pend_reg,    pend_next;     // ram data is a live slot
    logic                           res_vld_reg, res_vld_next;
    logic [hdc_pkg::SYM_FIELD_W-1:0] sym_reg,    sym_next;
    logic [hdc_pkg::LEN_FIELD_W-1:0] len_reg,    len_next;
    logic                           err_reg,     err_next;

    logic            accept;
    logic            load_beat;
    logic            rd_en;
    logic            hit;
    hdc_pkg::entry_t cur_entry;

    assign busy           = (state_reg != ST_IDLE);
    assign accept         = start && !busy;
    assign load_beat      = accept && (req_type == hdc_pkg::REQ_LOAD);
    assign rd_en          = (state_reg == ST_SCAN) && !issued_reg;
    assign result_valid   = res_vld_reg;
    assign symbol         = sym_reg;
    assign code_length    = len_reg;
    assign no_match_error = err_reg;

    // table storage, one slot read per cycle
    hdc_code_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SYMBOL_BITS   (SYMBOL_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_beat),
        .wr_index (entry_index),
        .wr_len   (entry_length),
        .wr_code  (entry_code),
        .wr_sym   (entry_symbol),
        .rd_en    (rd_en),
        .rd_addr  (issue_reg),
        .rd_entry (cur_entry)
    );

    // the one compare unit, reused for every slot
    hdc_match_unit #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_match (
        .entry (cur_entry),
        .acc   (acc_reg),
        .count (count_reg),
        .hit   (hit)
    );

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        issue_next   = issue_reg;
        issued_next  = issued_reg;
        pend_next    = pend_reg;
        res_vld_next = 1'b0;
        sym_next     = sym_reg;
        len_next     = len_reg;
        err_next     = err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == hdc_pkg::REQ_BIT))
                begin
                    // top bit is always clear here, since count is below full
                    acc_next    = {acc_reg[MAX_CODE_LEN-2:0], code_bit};
                    count_next  = count_reg + 1'b1;
                    fin_next    = final_bit;
                    issue_next  = '0;
                    issued_next = 1'b0;
                    pend_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read pipeline: issue the next slot while the previous one compares
                pend_next   = !issued_reg;
                issued_next = issued_reg || (issue_reg == LAST_IDX);
                if (!issued_reg && (issue_reg != LAST_IDX))
                begin
                    issue_next = issue_reg + 1'b1;
                end

                if (pend_reg && hit)
                begin
                    res_vld_next = 1'b1;
                    sym_next     = cur_entry.sym;
                    len_next     = hdc_pkg::LEN_FIELD_W'(count_reg);
                    err_next     = 1'b0;
                    acc_next     = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
                else if (pend_reg && issued_reg)
                begin
                    // last slot compared with no match
                    if ((count_reg >= FULL_CNT) || fin_reg)
                    begin
                        res_vld_next = 1'b1;
                        sym_next     = '0;
                        len_next     = hdc_pkg::LEN_FIELD_W'(count_reg);
                        err_next     = 1'b1;
                        acc_next     = '0;
                        count_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            count_reg   <= '0;
            fin_reg     <= 1'b0;
            issue_reg   <= '0;
            issued_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            issue_reg   <= issue_next;
            issued_reg  <= issued_next;
            pend_reg    <= pend_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // result payload, qualified by result_valid
    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
        len_reg <= len_next;
        err_reg <= err_next;
    end

endmodule

`default_nettype wire

// File: src/hdc_checker.sv
// port-level checks of the huffman bit-serial decoder, bound to the top level
// depends on hdc_pkg and huffman_bit_serial_decoder_core
`timescale 1ns / 1ps
`default_nettype none

module hdc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             req_type,
    input wire logic                             result_valid,
    input wire logic [hdc_pkg::SYM_FIELD_W-1:0]  symbol,
    input wire logic                             no_match_error
);

    // a result only appears as the walk ends
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // an error result carries a zero symbol
    a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && no_match_error) |-> (symbol == '0))
        else $error("error beat with nonzero symbol");

    // a load beat finishes in its own cycle and gives nothing
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == hdc_pkg::REQ_LOAD)) |=> (!busy && !result_valid))
        else $error("load beat caused busy or a result");

    // a bit beat always starts a table walk
    a_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == hdc_pkg::REQ_BIT)) |=> busy)
        else $error("bit beat did not start a walk");

    // a result strobe never repeats back to back
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

endmodule

bind huffman_bit_serial_decoder_core hdc_checker u_hdc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .result_valid   (result_valid),
    .symbol         (symbol),
    .no_match_error (no_match_error)
);

`default_nettype wire
